// ----- hw/rtl/sart_pkg.sv -----
// Package for the sorted address range table.
// Types, codes and sizes shared by the controller, datapath and top level.
// No dependencies.
package sart_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NOP    = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_RENAMED   = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    WS_NEW  = 2'd0,
    WS_HEAD = 2'd1,
    WS_TAIL = 2'd2,
    WS_COPY = 2'd3
  } wsel_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [63:0] address;
    logic [31:0] length;
    logic [15:0] tag;
  } req_t;

  typedef struct packed {
    stat_t       status;
    logic [15:0] found_tag;
    logic [31:0] offset;
  } rsp_t;

  typedef struct packed {
    logic [63:0] base;
    logic [31:0] len;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic  load;
    logic  probe;
    logic  eval;
    logic  j_init_up;
    logic  j_init_dn;
    logic  rd_up;
    logic  rd_dn;
    logic  wr_j;
    logic  dir_up;
    logic  wr_pos;
    wsel_t wsel;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  respond;
    logic  hit;
    stat_t status;
  } cmd_t;

  typedef struct packed {
    req_type_t new_type;
    req_type_t req_type;
    logic      cnt_zero;
    logic      full;
    logic      last;
    logic      lt;
    logic      contained;
    logic      exact;
    logic      off_zero;
    logic      len_whole;
    logic      tail_fit;
    logic      j_at_pos;
    logic      j_end_dn;
  } sts_t;

endpackage

// ----- hw/rtl/sart_dp.sv -----
// Datapath of the sorted address range table: entry memory, search bounds,
// shift index, entry count and result register. Uses sart_pkg.
module sart_dp (
  input  logic          clk,
  input  logic          rst,
  input  sart_pkg::req_t req,
  input  sart_pkg::cmd_t cmd,
  output sart_pkg::sts_t sts,
  output logic          done,
  output sart_pkg::rsp_t rsp
);

  sart_pkg::entry_t mem [sart_pkg::CAPACITY];
  sart_pkg::entry_t rdata;
  sart_pkg::entry_t wdata;
  sart_pkg::req_t   rq;
  logic [31:0]      slen;
  logic [sart_pkg::IDX_W-1:0] lo, hi, i;
  logic [sart_pkg::CNT_W-1:0] pos, j, count;
  logic [sart_pkg::IDX_W:0]   mid_sum;
  logic [sart_pkg::IDX_W-1:0] mid, raddr, waddr;
  logic [sart_pkg::CNT_W-1:0] j_dec, j_inc, cnt_m1;
  logic [64:0] diff;
  logic [63:0] off;
  logic [32:0] end_s, end_r;
  logic        lt, contained, we;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[sart_pkg::IDX_W:1];
  assign j_dec   = j - 1'b1;
  assign j_inc   = j + 1'b1;
  assign cnt_m1  = count - 1'b1;

  assign diff = {1'b0, rq.address} - {1'b0, rdata.base};
  assign lt   = diff[64];
  assign off  = diff[63:0];
  assign end_s = {1'b0, off[31:0]} + {1'b0, slen};
  assign end_r = {1'b0, off[31:0]} + {1'b0, rq.length};
  assign contained = !lt && (off[63:32] == 32'd0) && (end_s <= {1'b0, rdata.len});

  always_comb begin
    sts.new_type  = req.req_type;
    sts.req_type  = rq.req_type;
    sts.cnt_zero  = (count == '0);
    sts.full      = (count == sart_pkg::CNT_W'(sart_pkg::CAPACITY));
    sts.last      = (lo == hi);
    sts.lt        = lt;
    sts.contained = contained;
    sts.exact     = (rdata.base == rq.address) && (rdata.len == rq.length);
    sts.off_zero  = (off == 64'd0);
    sts.len_whole = (rq.length == 32'd0) || (rq.length == rdata.len);
    sts.tail_fit  = (end_r == {1'b0, rdata.len});
    sts.j_at_pos  = (j == pos);
    sts.j_end_dn  = (j_inc == count);
  end

  always_comb begin
    raddr = mid;
    if (cmd.rd_up) begin
      raddr = j_dec[sart_pkg::IDX_W-1:0];
    end else if (cmd.rd_dn) begin
      raddr = j_inc[sart_pkg::IDX_W-1:0];
    end
    we    = cmd.wr_j || cmd.wr_pos;
    waddr = cmd.wr_j ? j[sart_pkg::IDX_W-1:0] : pos[sart_pkg::IDX_W-1:0];
    case (cmd.wsel)
      sart_pkg::WS_NEW: begin
        wdata = '{base: rq.address, len: rq.length, tag: rq.tag};
      end
      sart_pkg::WS_HEAD: begin
        wdata = '{base: rdata.base + {32'd0, rq.length},
                  len: rdata.len - rq.length, tag: rdata.tag};
      end
      sart_pkg::WS_TAIL: begin
        wdata = '{base: rdata.base, len: off[31:0], tag: rdata.tag};
      end
      default: begin
        wdata = rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.probe || cmd.rd_up || cmd.rd_dn) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq   <= req;
      slen <= (req.req_type == sart_pkg::REQ_LOOKUP) ? 32'd0 : req.length;
      lo   <= '0;
      hi   <= cnt_m1[sart_pkg::IDX_W-1:0];
      pos  <= '0;
    end
    if (cmd.probe) begin
      i <= mid;
    end
    if (cmd.eval) begin
      if (lt) begin
        hi <= (i != '0 && i > lo) ? i - 1'b1 : i;
      end else begin
        lo <= i + 1'b1;
      end
      pos <= (lt || contained) ? {1'b0, i} : {1'b0, i} + 1'b1;
    end
    if (cmd.j_init_up) begin
      j <= count;
    end else if (cmd.j_init_dn) begin
      j <= {1'b0, i};
    end else if (cmd.wr_j) begin
      j <= cmd.dir_up ? j_dec : j_inc;
    end
    if (cmd.respond) begin
      rsp.status    <= cmd.status;
      rsp.found_tag <= cmd.hit ? rdata.tag : 16'd0;
      rsp.offset    <= cmd.hit ? off[31:0] : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.respond;
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= cnt_m1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= sart_pkg::CNT_W'(sart_pkg::CAPACITY)) else $error("count above capacity");
  a_inc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !sts.full) else $error("insert into full table");
  a_dec_some: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> !sts.cnt_zero) else $error("remove from empty table");
  a_one_wr: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_j && cmd.wr_pos)) else $error("two writes in one cycle");
`endif

endmodule

// ----- hw/rtl/sart_ctrl.sv -----
// Controller of the sorted address range table: search, shift and
// update sequencing. Drives sart_dp through cmd_t. Uses sart_pkg.
module sart_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sart_pkg::sts_t sts,
  output sart_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_PROBE  = 11'b00000000010,
    S_EVAL   = 11'b00000000100,
    S_UP_RD  = 11'b00000001000,
    S_UP_WR  = 11'b00000010000,
    S_DN_RD  = 11'b00000100000,
    S_DN_WR  = 11'b00001000000,
    S_INSERT = 11'b00010000000,
    S_RENAME = 11'b00100000000,
    S_HEAD   = 11'b01000000000,
    S_TAIL   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = sart_pkg::ST_IGNORED;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.new_type == sart_pkg::REQ_NOP) begin
            cmd.respond = 1'b1;
          end else if (sts.cnt_zero) begin
            if (sts.new_type == sart_pkg::REQ_ADD) begin
              state_next = S_INSERT;
            end else begin
              cmd.respond = 1'b1;
              cmd.status  = sart_pkg::ST_NOT_FOUND;
            end
          end else begin
            state_next = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        cmd.probe  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.lt && sts.contained) begin
          case (sts.req_type)
            sart_pkg::REQ_ADD: begin
              if (sts.exact) begin
                state_next = S_RENAME;
              end else begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
              end
            end
            sart_pkg::REQ_REMOVE: begin
              if (sts.off_zero && sts.len_whole) begin
                cmd.j_init_dn = 1'b1;
                state_next    = S_DN_RD;
              end else if (sts.off_zero) begin
                state_next = S_HEAD;
              end else if (sts.tail_fit) begin
                state_next = S_TAIL;
              end else begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
              end
            end
            default: begin
              cmd.respond = 1'b1;
              cmd.hit     = 1'b1;
              cmd.status  = sart_pkg::ST_DONE;
              state_next  = S_IDLE;
            end
          endcase
        end else if (!sts.last) begin
          state_next = S_PROBE;
        end else if (sts.req_type == sart_pkg::REQ_ADD) begin
          if (sts.full) begin
            cmd.respond = 1'b1;
            cmd.status  = sart_pkg::ST_FULL;
            state_next  = S_IDLE;
          end else begin
            cmd.j_init_up = 1'b1;
            state_next    = S_UP_RD;
          end
        end else begin
          cmd.respond = 1'b1;
          cmd.status  = sart_pkg::ST_NOT_FOUND;
          state_next  = S_IDLE;
        end
      end
      S_UP_RD: begin
        if (sts.j_at_pos) begin
          state_next = S_INSERT;
        end else begin
          cmd.rd_up  = 1'b1;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_j   = 1'b1;
        cmd.dir_up = 1'b1;
        cmd.wsel   = sart_pkg::WS_COPY;
        state_next = S_UP_RD;
      end
      S_DN_RD: begin
        if (sts.j_end_dn) begin
          cmd.cnt_dec = 1'b1;
          cmd.respond = 1'b1;
          cmd.status  = sart_pkg::ST_DONE;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_dn  = 1'b1;
          state_next = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr_j   = 1'b1;
        cmd.wsel   = sart_pkg::WS_COPY;
        state_next = S_DN_RD;
      end
      S_INSERT: begin
        cmd.wr_pos  = 1'b1;
        cmd.wsel    = sart_pkg::WS_NEW;
        cmd.cnt_inc = 1'b1;
        cmd.respond = 1'b1;
        cmd.status  = sart_pkg::ST_DONE;
        state_next  = S_IDLE;
      end
      S_RENAME: begin
        cmd.wr_pos  = 1'b1;
        cmd.wsel    = sart_pkg::WS_NEW;
        cmd.respond = 1'b1;
        cmd.status  = sart_pkg::ST_RENAMED;
        state_next  = S_IDLE;
      end
      S_HEAD: begin
        cmd.wr_pos  = 1'b1;
        cmd.wsel    = sart_pkg::WS_HEAD;
        cmd.respond = 1'b1;
        cmd.status  = sart_pkg::ST_DONE;
        state_next  = S_IDLE;
      end
      S_TAIL: begin
        cmd.wr_pos  = 1'b1;
        cmd.wsel    = sart_pkg::WS_TAIL;
        cmd.respond = 1'b1;
        cmd.status  = sart_pkg::ST_DONE;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_resp_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> state == S_IDLE) else $error("reply without return to idle");
  a_probe_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.probe |=> cmd.eval) else $error("probe not followed by evaluation");
`endif

endmodule

// ----- hw/rtl/sorted_address_range_table.sv -----
// Top level of the sorted address range table.
// Joins sart_ctrl and sart_dp. Uses sart_pkg.
//
//   channel  | handshake     | payload
//   request  | start / busy  | req (req_type, address, length, tag)
//   result   | done strobe   | rsp (status, found_tag, offset)
//
// Each binary search probe is a read (S_PROBE), then a compare (S_EVAL); an
// insert or whole-entry remove also moves entries, each with a read, then a
// write (S_UP_RD/S_UP_WR or S_DN_RD/S_DN_WR).
// The result shows in the cycle after the last step; busy is already low then.
// Reset (rst, synchronous) empties the table; no clearing pass is run.
// The receiver cannot stall; done is not held, but rsp keeps its value until the next result.
module sorted_address_range_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sart_pkg::req_t req,
  output logic           done,
  output sart_pkg::rsp_t rsp
);

  sart_pkg::cmd_t cmd;
  sart_pkg::sts_t sts;

  sart_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sart_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .done (done),
    .rsp  (rsp)
  );

endmodule
